/* design/arrf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arrf_pkg
// Shared widths, register map and reset values for the adaptive row
// region-of-interest finder.
// ----------------------------------------------------------------------------
package arrf_pkg;

  // image size limits; the output widths below are sized for them
  localparam int unsigned MAX_ROWS  = 1024;
  localparam int unsigned MAX_COLS  = 2048;

  localparam int unsigned PIX_W     = 16;
  localparam int unsigned ROW_ACC_W = 27;
  localparam int unsigned TOTAL_W   = 37;
  localparam int unsigned ROWS_W    = 11;
  localparam int unsigned ERATIO_W  = 17;
  localparam int unsigned MRATIO_W  = 16;
  localparam int unsigned Q_FRAC    = 16;
  localparam int unsigned TARGET_W  = TOTAL_W + ERATIO_W;
  localparam int unsigned START_W   = 10;
  localparam int unsigned HEIGHT_W  = 11;
  localparam int unsigned PADDR_W   = 4;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [ROW_ACC_W-1:0] ROW_ACC_SAT = {ROW_ACC_W{1'b1}};
  localparam logic [TOTAL_W-1:0]   TOTAL_SAT   = {TOTAL_W{1'b1}};

  // floor(x/5) == (x * 13108) >> 16 for every x below 2^14
  localparam logic [13:0] DIV5_MUL = 14'd13108;
  localparam int unsigned DIV5_W   = 14;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_IMAGE_ROWS   = 2'd0;
  localparam logic [1:0] REG_ENERGY_RATIO = 2'd1;
  localparam logic [1:0] REG_MARGIN_RATIO = 2'd2;

  localparam logic [ROWS_W-1:0]   IMAGE_ROWS_RST   = 11'd375;
  localparam logic [ERATIO_W-1:0] ENERGY_RATIO_RST = 17'd52429;
  localparam logic [MRATIO_W-1:0] MARGIN_RATIO_RST = 16'd6554;

endpackage

/* design/adaptive_row_roi_finder_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_row_roi_finder_top
// Sums positive disparity per row into a row-energy memory and, at frame
// end, runs a two-pointer search for the shortest band holding the given
// energy fraction, then widens, clamps and, if too short, re-centres it.
// ----------------------------------------------------------------------------
//
//  channel | handshake                  | payload
//  --------+----------------------------+-----------------------------------
//  in      | in_valid_i / in_stall_o    | disparity_i, end_of_row_i,
//          |                            | end_of_frame_i
//  out     | out_valid_o / out_stall_i  | roi_start_o, roi_height_o
//  cfg     | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
//  pixels are taken one per cycle while no search runs and no result waits to be loaded.
//  after the end-of-frame pixel the search steps both pointers over one shared
//  memory read port: each bottom pointer move passes through read, add, top
//  read and best states, each top pointer move through check and read, and
//  each row enters and leaves the window at most once. in_stall_o is high
//  meanwhile. a zero-energy frame goes from init straight to emit.
//  the result waits in an output register; if it is still stalled when the
//  next search ends, the block holds until it is taken.
//  reset clears control state only; the row memory is not cleared.
// ----------------------------------------------------------------------------
module adaptive_row_roi_finder_top
  import arrf_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // pixel requests
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [PIX_W-1:0]     disparity_i,
  input  logic                        end_of_row_i,
  input  logic                        end_of_frame_i,
  // region requests
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [START_W-1:0]          roi_start_o,
  output logic [HEIGHT_W-1:0]         roi_height_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [PADDR_W-1:0]          paddr,
  input  logic [PDATA_W-1:0]          pwdata,
  output logic [PDATA_W-1:0]          prdata,
  output logic                        pready
);

  localparam int unsigned CW  = $clog2(MAX_ROWS + 1);
  localparam int unsigned AW  = $clog2(MAX_ROWS);
  localparam int unsigned SW  = CW + 3;
  localparam int unsigned XW  = (CW > ROWS_W) ? CW : ROWS_W;
  localparam int unsigned P5W = CW + DIV5_W;
  localparam int unsigned PMW = CW + MRATIO_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INIT    = 4'd1;
  localparam logic [3:0] S_BOT_RD  = 4'd2;
  localparam logic [3:0] S_BOT_ADD = 4'd3;
  localparam logic [3:0] S_TOP_RD  = 4'd4;
  localparam logic [3:0] S_TOP_CHK = 4'd5;
  localparam logic [3:0] S_BEST    = 4'd6;
  localparam logic [3:0] S_MARGIN  = 4'd7;
  localparam logic [3:0] S_CLAMP   = 4'd8;
  localparam logic [3:0] S_FIX     = 4'd9;
  localparam logic [3:0] S_FIX2    = 4'd10;
  localparam logic [3:0] S_EMIT    = 4'd11;

  logic [3:0]             state_q, state_d;
  logic [ROWS_W-1:0]      rows_q;
  logic [ERATIO_W-1:0]    eratio_q;
  logic [MRATIO_W-1:0]    mratio_q;
  logic [ROW_ACC_W-1:0]   acc_q;
  logic [TOTAL_W-1:0]     total_q;
  logic [CW-1:0]          rcv_q;
  logic                   out_valid_q;
  logic [START_W-1:0]     out_start_q;
  logic [HEIGHT_W-1:0]    out_height_q;

  logic [TOTAL_W-1:0]     sum_q;
  logic [CW-1:0]          top_q, bot_q;
  logic [CW-1:0]          best_h_q, best_s_q;
  logic [TARGET_W-1:0]    target_q;
  logic [CW-1:0]          margin_q, min_h_q;
  logic signed [SW-1:0]   y0_q, y1_q, h_q;

  logic [ROW_ACC_W-1:0]   mem [MAX_ROWS];
  logic [ROW_ACC_W-1:0]   rd_q;
  logic [AW-1:0]          rd_addr;

  logic                   in_acc, cfg_wr, row_close, row_store, out_load;
  logic [ROW_ACC_W-1:0]   pix_e, acc_new;
  logic [ROW_ACC_W:0]     acc_sum;
  logic [TOTAL_W:0]       tot_sum;
  logic [TOTAL_W-1:0]     tot_new;
  logic [XW-1:0]          rows_x;
  logic [CW-1:0]          rows_eff, hh;
  logic [ROW_ACC_W-1:0]   e_top, e_bot;
  logic [TOTAL_W-1:0]     sum_less;
  logic [TARGET_W-1:0]    less_scaled, sum_scaled;
  logic [P5W-1:0]         prod5;
  logic [PMW-1:0]         prodm;
  logic [CW-1:0]          min5;
  logic signed [SW-1:0]   rows_s, y0c, y1c, hc, cs, centre, y0r, y1r;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      REG_IMAGE_ROWS:   prdata = PDATA_W'(rows_q);
      REG_ENERGY_RATIO: prdata = PDATA_W'(eratio_q);
      REG_MARGIN_RATIO: prdata = PDATA_W'(mratio_q);
      default:          prdata = '0;
    endcase
  end

  always_comb begin
    rows_x = XW'(rows_q);
    if (rows_x == '0) begin
      rows_eff = CW'(1);
    end else if (rows_x > XW'(MAX_ROWS)) begin
      rows_eff = CW'(MAX_ROWS);
    end else begin
      rows_eff = CW'(rows_x);
    end
  end

  // ---------------------------------------------------------------- pixels
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign row_close  = end_of_row_i || end_of_frame_i;
  assign row_store  = in_acc && row_close && (rcv_q < rows_eff);

  always_comb begin
    pix_e   = (disparity_i > 0) ? ROW_ACC_W'($unsigned(disparity_i)) : '0;
    acc_sum = {1'b0, acc_q} + {1'b0, pix_e};
    acc_new = acc_sum[ROW_ACC_W] ? ROW_ACC_SAT : acc_sum[ROW_ACC_W-1:0];
    tot_sum = {1'b0, total_q} + (TOTAL_W + 1)'(acc_new);
    tot_new = tot_sum[TOTAL_W] ? TOTAL_SAT : tot_sum[TOTAL_W-1:0];
  end

  // ---------------------------------------------------------------- memory
  assign rd_addr = (state_q == S_TOP_RD) ? top_q[AW-1:0] : bot_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (row_store) begin
      mem[rcv_q[AW-1:0]] <= acc_new;
    end
    rd_q <= mem[rd_addr];
  end

  // rows not received this frame read as zero energy
  assign e_bot = (bot_q < rcv_q) ? rd_q : '0;
  assign e_top = (top_q < rcv_q) ? rd_q : '0;

  // ---------------------------------------------------------------- search
  always_comb begin
    sum_less    = sum_q - TOTAL_W'(e_top);
    less_scaled = TARGET_W'({sum_less, {Q_FRAC{1'b0}}});
    sum_scaled  = TARGET_W'({sum_q, {Q_FRAC{1'b0}}});
    hh          = bot_q - top_q;
    prod5       = P5W'(rows_eff) * P5W'(DIV5_MUL);
    min5        = CW'(prod5 >> Q_FRAC);
    prodm       = PMW'(rows_eff) * PMW'(mratio_q);
    rows_s      = $signed(SW'(rows_eff));
    y0c         = $signed(SW'(best_s_q)) - $signed(SW'(margin_q));
    y1c         = $signed(SW'(best_s_q)) + $signed(SW'(best_h_q)) - SW'(1)
                  + $signed(SW'(margin_q));
    hc          = y1_q - y0_q + SW'(1);
    cs          = y0_q + y1_q;
    // quotient toward zero: only -1 can be negative here
    centre      = (cs < 0) ? '0 : (cs >>> 1);
    y0r         = centre - $signed(SW'(min_h_q >> 1));
    y1r         = y0_q + $signed(SW'(min_h_q)) - SW'(1);
  end

  assign out_load = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (in_acc && end_of_frame_i) state_d = S_INIT;
      S_INIT:    state_d = (total_q == '0) ? S_EMIT : S_BOT_RD;
      S_BOT_RD:  state_d = (bot_q < rows_eff) ? S_BOT_ADD : S_MARGIN;
      S_BOT_ADD: state_d = S_TOP_RD;
      S_TOP_RD:  state_d = (top_q < bot_q) ? S_TOP_CHK : S_BEST;
      S_TOP_CHK: state_d = (less_scaled >= target_q) ? S_TOP_RD : S_BEST;
      S_BEST:    state_d = S_BOT_RD;
      S_MARGIN:  state_d = S_CLAMP;
      S_CLAMP:   state_d = S_FIX;
      S_FIX:     state_d = (hc < $signed(SW'(min_h_q))) ? S_FIX2 : S_EMIT;
      S_FIX2:    state_d = S_EMIT;
      S_EMIT:    if (out_load) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rows_q      <= IMAGE_ROWS_RST;
      eratio_q    <= ENERGY_RATIO_RST;
      mratio_q    <= MARGIN_RATIO_RST;
      acc_q       <= '0;
      total_q     <= '0;
      rcv_q       <= '0;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
      top_q       <= '0;
      bot_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_IMAGE_ROWS:   rows_q   <= pwdata[ROWS_W-1:0];
          REG_ENERGY_RATIO: eratio_q <= pwdata[ERATIO_W-1:0];
          REG_MARGIN_RATIO: mratio_q <= pwdata[MRATIO_W-1:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        acc_q <= row_close ? '0 : acc_new;
      end
      if (row_store) begin
        total_q <= tot_new;
        rcv_q   <= rcv_q + CW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        total_q     <= '0;
        rcv_q       <= '0;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_INIT: begin
          sum_q <= '0;
          top_q <= '0;
          bot_q <= '0;
        end
        S_BOT_ADD: begin
          sum_q <= sum_q + TOTAL_W'(e_bot);
          bot_q <= bot_q + CW'(1);
        end
        S_TOP_CHK: begin
          if (less_scaled >= target_q) begin
            sum_q <= sum_less;
            top_q <= top_q + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_INIT: begin
        target_q <= TARGET_W'(total_q) * TARGET_W'(eratio_q);
        best_h_q <= rows_eff;
        best_s_q <= rows_eff >> 2;
        // zero-energy frame result
        y0_q     <= $signed(SW'(rows_eff >> 2));
        h_q      <= $signed(SW'(rows_eff >> 1));
      end
      S_BEST: begin
        if (sum_scaled >= target_q && hh < best_h_q) begin
          best_h_q <= hh;
          best_s_q <= top_q;
        end
      end
      S_MARGIN: begin
        margin_q <= CW'(prodm >> Q_FRAC);
        min_h_q  <= (min5 == '0) ? CW'(1) : min5;
      end
      S_CLAMP: begin
        y0_q <= (y0c < 0) ? '0 : y0c;
        y1_q <= (y1c > rows_s - SW'(1)) ? rows_s - SW'(1) : y1c;
      end
      S_FIX: begin
        if (hc < $signed(SW'(min_h_q))) begin
          y0_q <= (y0r < 0) ? '0 : y0r;
        end else begin
          h_q <= hc;
        end
      end
      S_FIX2: begin
        if (y1r > rows_s - SW'(1)) begin
          h_q <= rows_s - y0_q;
        end else begin
          h_q <= y1r - y0_q + SW'(1);
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_start_q  <= START_W'($unsigned(y0_q));
      out_height_q <= HEIGHT_W'($unsigned(h_q));
    end
  end

  assign out_valid_o  = out_valid_q;
  assign roi_start_o  = out_start_q;
  assign roi_height_o = out_height_q;

  // ------------------------------------------------------------ assertions
  a_eof_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && end_of_frame_i) |=> in_stall_o)
    else $error("search did not start after end of frame");

  a_window_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TOP_RD || state_q == S_TOP_CHK || state_q == S_BEST)
      |-> (top_q <= bot_q && bot_q <= rows_eff))
    else $error("window pointers out of order");

  a_window_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TOP_RD || state_q == S_TOP_CHK || state_q == S_BEST)
      |-> (sum_q <= total_q))
    else $error("window sum exceeds frame total");

  a_search_idle_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_load) |=> (state_q == S_IDLE && out_valid_q))
    else $error("result not presented after search");

endmodule

/* test/arrf_region_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arrf_region_checker
// Watches the pixel, region and register ports of the row region finder,
// keeps its own copy of the row energies and registers, predicts the region
// of every frame and compares it with what the block returns.
// ----------------------------------------------------------------------------
module arrf_region_checker
  import arrf_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic signed [PIX_W-1:0] disparity_i,
  input  logic                    end_of_row_i,
  input  logic                    end_of_frame_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [START_W-1:0]      roi_start_i,
  input  logic [HEIGHT_W-1:0]     roi_height_i,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [PDATA_W-1:0]      pwdata,
  input  logic [PDATA_W-1:0]      prdata,
  input  logic                    pready,
  output int                      pending_o,
  output int                      failures_o
);

  typedef struct packed {
    logic [START_W-1:0]  start;
    logic [HEIGHT_W-1:0] height;
  } region_t;

  logic [ROWS_W-1:0]    cfg_rows;
  logic [ERATIO_W-1:0]  cfg_eratio;
  logic [MRATIO_W-1:0]  cfg_mratio;

  logic [ROW_ACC_W-1:0] row_energy [MAX_ROWS];
  logic [ROW_ACC_W-1:0] row_sum;
  logic [TOTAL_W-1:0]   frame_total;
  int                   rows_seen;
  region_t              expected_regions [$];
  region_t              want;
  int                   fail_count = 0;
  int                   queued = 0;

  assign pending_o  = queued;
  assign failures_o = fail_count;

  function automatic int rows_in_use();
    if (cfg_rows == 0) return 1;
    if (cfg_rows > MAX_ROWS) return MAX_ROWS;
    return int'(cfg_rows);
  endfunction

  // rows not received in this frame hold no energy
  function automatic logic [63:0] energy_at(int r);
    if (r < rows_seen && r < MAX_ROWS) return 64'(row_energy[r]);
    return 64'd0;
  endfunction

  function automatic logic [PDATA_W-1:0] reg_value(logic [1:0] idx);
    case (idx)
      REG_IMAGE_ROWS:   return PDATA_W'(cfg_rows);
      REG_ENERGY_RATIO: return PDATA_W'(cfg_eratio);
      REG_MARGIN_RATIO: return PDATA_W'(cfg_mratio);
      default:          return '0;
    endcase
  endfunction

  // shortest band reaching the energy share, then margin, clamp and re-centre
  function automatic region_t search_band();
    int          rows, margin, y0, y1, h, min_h, centre, bh, bs, top, bot;
    logic [63:0] target, wsum;
    region_t     r;
    rows = rows_in_use();
    if (frame_total == 0) begin
      y0 = rows / 4;
      h  = rows / 2;
      r.start  = y0[START_W-1:0];
      r.height = h[HEIGHT_W-1:0];
      return r;
    end
    target = 64'(frame_total) * 64'(cfg_eratio);
    bh = rows;
    bs = rows / 4;
    top = 0;
    bot = 0;
    wsum = '0;
    while (bot < rows) begin
      wsum = wsum + energy_at(bot);
      bot++;
      while (top < bot && ((wsum - energy_at(top)) << Q_FRAC) >= target) begin
        wsum = wsum - energy_at(top);
        top++;
      end
      if ((wsum << Q_FRAC) >= target && (bot - top) < bh) begin
        bh = bot - top;
        bs = top;
      end
    end
    margin = (rows * int'(cfg_mratio)) >>> Q_FRAC;
    y0 = bs - margin;
    if (y0 < 0) y0 = 0;
    y1 = bs + bh - 1 + margin;
    if (y1 > rows - 1) y1 = rows - 1;
    h = y1 - y0 + 1;
    min_h = rows / 5;
    if (min_h < 1) min_h = 1;
    if (h < min_h) begin
      centre = (y0 + y1) / 2;
      y0 = centre - min_h / 2;
      if (y0 < 0) y0 = 0;
      y1 = y0 + min_h - 1;
      if (y1 > rows - 1) y1 = rows - 1;
      h = y1 - y0 + 1;
    end
    r.start  = y0[START_W-1:0];
    r.height = h[HEIGHT_W-1:0];
    return r;
  endfunction

  task automatic commit_row();
    logic [TOTAL_W:0] t;
    // rows past the image height are dropped
    if (rows_seen < rows_in_use()) begin
      row_energy[rows_seen] = row_sum;
      t = {1'b0, frame_total} + (TOTAL_W + 1)'(row_sum);
      frame_total = (t > TOTAL_SAT) ? TOTAL_SAT : t[TOTAL_W-1:0];
      rows_seen++;
    end
    row_sum = '0;
  endtask

  task automatic take_pixel(logic signed [PIX_W-1:0] d, logic eor, logic eof);
    logic [ROW_ACC_W:0] s;
    if (d > 0) begin
      s = {1'b0, row_sum} + (ROW_ACC_W + 1)'(unsigned'(d));
      row_sum = (s > ROW_ACC_SAT) ? ROW_ACC_SAT : s[ROW_ACC_W-1:0];
    end
    if (eor || eof) commit_row();
    if (eof) begin
      expected_regions = {expected_regions, search_band()};
      row_sum = '0;
      frame_total = '0;
      rows_seen = 0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_rows    = IMAGE_ROWS_RST;
      cfg_eratio  = ENERGY_RATIO_RST;
      cfg_mratio  = MARGIN_RATIO_RST;
      row_sum     = '0;
      frame_total = '0;
      rows_seen   = 0;
      expected_regions.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[3:2])
            REG_IMAGE_ROWS:   cfg_rows   = pwdata[ROWS_W-1:0];
            REG_ENERGY_RATIO: cfg_eratio = pwdata[ERATIO_W-1:0];
            REG_MARGIN_RATIO: cfg_mratio = pwdata[MRATIO_W-1:0];
            default: ;
          endcase
        end else if (prdata !== reg_value(paddr[3:2])) begin
          $display("%0t: register %0d read expected %0h, got %0h", $time, paddr[3:2],
                   reg_value(paddr[3:2]), prdata);
          fail_count++;
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_regions.size() == 0) begin
          $display("%0t: region expected none, got start %0d height %0d", $time,
                   roi_start_i, roi_height_i);
          fail_count++;
        end else begin
          want = expected_regions.pop_front();
          if (roi_start_i !== want.start) begin
            $display("%0t: roi_start expected %0d, got %0d", $time, want.start, roi_start_i);
            fail_count++;
          end
          if (roi_height_i !== want.height) begin
            $display("%0t: roi_height expected %0d, got %0d", $time, want.height,
                     roi_height_i);
            fail_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) take_pixel(disparity_i, end_of_row_i, end_of_frame_i);
    end
    queued = expected_regions.size();
  end

endmodule

/* test/adaptive_row_roi_finder_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adaptive_row_roi_finder_top_tb
// Feeds disparity frames of varied shape and energy through the region
// finder under a series of register settings and idle patterns; the region
// checker predicts every frame's region and counts mismatches.
// ----------------------------------------------------------------------------
module adaptive_row_roi_finder_top_tb;
  import arrf_pkg::*;

  localparam int NUM_PHASES   = 16;
  localparam int PHASE_PIXELS = 102;
  localparam int LIMIT_ROWS   = 1024;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic signed [PIX_W-1:0] disparity_i;
  logic                    end_of_row_i;
  logic                    end_of_frame_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic [START_W-1:0]      roi_start_o;
  logic [HEIGHT_W-1:0]     roi_height_o;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [PADDR_W-1:0]      paddr;
  logic [PDATA_W-1:0]      pwdata;
  logic [PDATA_W-1:0]      prdata;
  logic                    pready;

  int gap_pct;
  int stall_pct;
  int pixels_sent;
  int frames_sent;
  int pending;
  int failures;

  adaptive_row_roi_finder_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .disparity_i    (disparity_i),
    .end_of_row_i   (end_of_row_i),
    .end_of_frame_i (end_of_frame_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .roi_start_o    (roi_start_o),
    .roi_height_o   (roi_height_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  arrf_region_checker u_region_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .disparity_i    (disparity_i),
    .end_of_row_i   (end_of_row_i),
    .end_of_frame_i (end_of_frame_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .roi_start_i    (roi_start_o),
    .roi_height_i   (roi_height_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .pending_o      (pending),
    .failures_o     (failures)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic set_idling(int mode);
    case (mode)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 82; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 82; end
      default: begin gap_pct = 9; stall_pct = 9; end
    endcase
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic push_pixel(logic [PIX_W-1:0] d, logic eor, logic eof);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    disparity_i    <= d;
    end_of_row_i   <= eor;
    end_of_frame_i <= eof;
    do @(posedge clk_i); while (in_stall_o);
    pixels_sent++;
    if (eof) frames_sent++;
    @(negedge clk_i);
  endtask

  task automatic cfg_access(logic wr, logic [1:0] idx, logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apply_setting(int unsigned rows, int unsigned eratio, int unsigned mratio);
    cfg_access(1'b1, REG_IMAGE_ROWS, PDATA_W'(rows));
    cfg_access(1'b1, REG_ENERGY_RATIO, PDATA_W'(eratio));
    cfg_access(1'b1, REG_MARGIN_RATIO, PDATA_W'(mratio));
    cfg_access(1'b0, REG_IMAGE_ROWS, '0);
    cfg_access(1'b0, REG_ENERGY_RATIO, '0);
    cfg_access(1'b0, REG_MARGIN_RATIO, '0);
  endtask

  // fixed corners first, random settings after, mostly short images
  task automatic pick_setting(input int p, output int unsigned rows,
                              output int unsigned eratio, output int unsigned mratio);
    int unsigned k;
    case (p)
      1: begin rows = 0;    eratio = 0;     mratio = 0;     end
      2: begin rows = 1;    eratio = 65536; mratio = 65535; end
      3: begin rows = 2047; eratio = 65536; mratio = 0;     end
      4: begin rows = 1024; eratio = 32768; mratio = 65535; end
      5: begin rows = 8;    eratio = 98304; mratio = 6554;  end
      6: begin rows = 16;   eratio = 1;     mratio = 20000; end
      7: begin rows = 5;    eratio = 65535; mratio = 32768; end
      default: begin
        k = $urandom_range(99);
        if (k < 70)      rows = $urandom_range(1, 48);
        else if (k < 80) rows = $urandom_range(49, 400);
        else if (k < 86) rows = 0;
        else if (k < 93) rows = $urandom_range(1025, 2047);
        else             rows = $urandom_range(401, 1024);
        k = $urandom_range(99);
        if (k < 10)      eratio = 0;
        else if (k < 20) eratio = 65536;
        else             eratio = $urandom_range(0, 65536);
        mratio = $urandom_range(0, 65535);
      end
    endcase
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(bit quiet, bit hot);
    int unsigned k;
    k = $urandom_range(99);
    if (quiet) begin
      if (k < 10) return '0;
      if (k < 20) return 16'h8000;
      return 16'(0 - $urandom_range(32768));
    end
    if (k < 8)  return 16'($urandom);
    if (k < 11) return 16'h7fff;
    if (k < 14) return 16'h8000;
    if (k < 17) return 16'd1;
    if (k < 22) return '0;
    if (k < 30) return 16'(0 - $urandom_range(32768, 1));
    if (hot)    return 16'($urandom_range(1000, 32767));
    return 16'($urandom_range(0, 300));
  endfunction

  // one frame of n_rows rows; energy mostly sits in a narrow band of rows
  task automatic send_frame(int n_rows);
    int  cols, hot_lo, hot_hi;
    bit  quiet, last;
    quiet  = ($urandom_range(9) == 0);
    hot_lo = $urandom_range(0, n_rows - 1);
    hot_hi = hot_lo + $urandom_range(0, 3);
    for (int r = 0; r < n_rows; r++) begin
      cols = $urandom_range(1, 3);
      for (int c = 0; c < cols; c++) begin
        last = (r == n_rows - 1) && (c == cols - 1);
        if (last)
          push_pixel(pick_pixel(quiet, r >= hot_lo && r <= hot_hi),
                     1'($urandom_range(1)), 1'b1);
        else
          push_pixel(pick_pixel(quiet, r >= hot_lo && r <= hot_hi), c == cols - 1, 1'b0);
      end
    end
  endtask

  function automatic int frame_rows(int rows_eff);
    int unsigned k;
    k = $urandom_range(99);
    if (rows_eff > 48) return $urandom_range(1, 12);
    if (k < 50) return rows_eff;
    if (k < 75) return $urandom_range(1, rows_eff);
    return rows_eff + $urandom_range(1, 3);
  endfunction

  initial begin : stimulus
    int unsigned rows_cfg, ratio_cfg, margin_cfg;
    int          rows_eff, phase_start;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    disparity_i    = '0;
    end_of_row_i   = 1'b0;
    end_of_frame_i = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    gap_pct        = 0;
    stall_pct      = 0;
    pixels_sent    = 0;
    frames_sent    = 0;
    rows_cfg       = IMAGE_ROWS_RST;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    cfg_access(1'b0, REG_IMAGE_ROWS, '0);
    cfg_access(1'b0, REG_ENERGY_RATIO, '0);
    cfg_access(1'b0, REG_MARGIN_RATIO, '0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        pick_setting(p, rows_cfg, ratio_cfg, margin_cfg);
        apply_setting(rows_cfg, ratio_cfg, margin_cfg);
      end
      set_idling(p % 4);
      rows_eff = (rows_cfg == 0) ? 1 : ((rows_cfg > LIMIT_ROWS) ? LIMIT_ROWS : rows_cfg);

      if (p == 0) begin
        // zero-energy frames: a lone zero, then the most negative pixel
        push_pixel('0, 1'b0, 1'b1);
        push_pixel(16'h8000, 1'b1, 1'b1);
        // energy in rows 0 and 2, then rows 0 and 1; frame end with and without row end
        push_pixel(16'h7fff, 1'b1, 1'b0);
        push_pixel(16'hffff, 1'b1, 1'b0);
        push_pixel(16'd1, 1'b1, 1'b1);
        push_pixel(16'h8000, 1'b0, 1'b0);
        push_pixel(16'd5, 1'b1, 1'b0);
        push_pixel(16'd7, 1'b0, 1'b1);
        // one row closed only by the frame end
        push_pixel(16'd100, 1'b0, 1'b0);
        push_pixel(16'd200, 1'b0, 1'b0);
        push_pixel(16'd300, 1'b0, 1'b1);
        push_pixel(16'd1, 1'b0, 1'b1);
      end

      phase_start = pixels_sent;
      while (pixels_sent - phase_start < PHASE_PIXELS) send_frame(frame_rows(rows_eff));
      in_valid_i <= 1'b0;
      // block goes quiet once the last region is out
      while (pending != 0) @(negedge clk_i);
      repeat (16) @(negedge clk_i);
    end

    $display("%0d pixels in %0d frames over %0d register settings and four idle patterns",
             pixels_sent, frames_sent, NUM_PHASES);
    $display("%0d mismatches found", failures);
    if (failures == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

/* filelist.f */
design/arrf_pkg.sv
design/adaptive_row_roi_finder_top.sv
test/arrf_region_checker.sv
test/adaptive_row_roi_finder_top_tb.sv
